FILE: rtl/mdt_pkg.sv
// Shared types and constants for the multibyte delimiter tokenizer.
// Depends on nothing; every other file in rtl imports it.
package mdt_pkg;

    localparam int BYTE_W    = 8;
    localparam int DELIM_W   = 17;
    localparam int COUNT_W   = 3;
    localparam int CFG_IDX_W = 3;

    // Delimiter entry layout: flag, second byte, first byte.
    localparam int DELIM_TWO_BIT = 16;

    // Byte class boundaries for the two encodings.
    localparam logic [BYTE_W-1:0] HIGH_MIN    = 8'h80;
    localparam logic [BYTE_W-1:0] SJIS_L1_MIN = 8'h81;
    localparam logic [BYTE_W-1:0] SJIS_L1_MAX = 8'h9f;
    localparam logic [BYTE_W-1:0] SJIS_L2_MIN = 8'he0;
    localparam logic [BYTE_W-1:0] SJIS_HI_MAX = 8'hfc;
    localparam logic [BYTE_W-1:0] SJIS_T1_MIN = 8'h40;
    localparam logic [BYTE_W-1:0] SJIS_T1_MAX = 8'h7e;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENCODING    = 3'd0,
        CFG_DELIM_COUNT = 3'd1,
        CFG_DELIM_0     = 3'd2,
        CFG_DELIM_1     = 3'd3,
        CFG_DELIM_2     = 3'd4,
        CFG_DELIM_3     = 3'd5
    } cfg_idx_t;

    // Work produced by one input word: up to two characters and an end mark.
    // The second character is always a single byte.
    typedef struct packed {
        logic              c0_valid;
        logic [BYTE_W-1:0] c0_first;
        logic [BYTE_W-1:0] c0_second;
        logic              c0_two;
        logic              c1_valid;
        logic [BYTE_W-1:0] c1_byte;
        logic              end_mark;
    } bundle_t;

endpackage

FILE: rtl/mdt_if.sv
// Valid/ready channel interfaces for the tokenizer's byte input and
// character output. Depends on mdt_pkg.
interface mdt_in_if;
    import mdt_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface mdt_out_if;
    import mdt_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] first_byte;
    logic [BYTE_W-1:0] second_byte;
    logic              two_byte;
    logic              in_token;
    logic              token_start;
    logic              end_marker;

    modport source (output valid, output first_byte, output second_byte, output two_byte,
                    output in_token, output token_start, output end_marker, input ready);
    modport sink   (input valid, input first_byte, input second_byte, input two_byte,
                    input in_token, input token_start, input end_marker, output ready);
endinterface

FILE: rtl/mdt_front.sv
// Front end: accepts input bytes, pairs them into characters under the
// selected encoding and hands the result to the queue. Depends on mdt_pkg, mdt_if.
module mdt_front (
    input  logic            clk,
    input  logic            rst_n,
    mdt_in_if.sink          in_ch,
    input  logic            encoding_mode,
    output mdt_pkg::bundle_t push_data,
    output logic            push_valid,
    input  logic            push_ready
);
    import mdt_pkg::*;

    logic [BYTE_W-1:0] pend_byte_reg, pend_byte_next;
    logic              pend_valid_reg, pend_valid_next;
    logic              term_reg, term_next;
    logic              accept;
    bundle_t           bundle;

    // Decide whether lead and trail bytes form one two-byte character.
    function automatic logic pair_forms(input logic euc, input logic [BYTE_W-1:0] lead,
                                        input logic [BYTE_W-1:0] trail);
        logic lead_ok;
        logic trail_ok;
        lead_ok  = (lead >= SJIS_L1_MIN && lead <= SJIS_L1_MAX) ||
                   (lead >= SJIS_L2_MIN && lead <= SJIS_HI_MAX);
        trail_ok = (trail >= SJIS_T1_MIN && trail <= SJIS_T1_MAX) ||
                   (trail >= HIGH_MIN && trail <= SJIS_HI_MAX);
        if (euc)
            return (lead >= HIGH_MIN) && (trail >= HIGH_MIN);
        return lead_ok && trail_ok;
    endfunction

    assign in_ch.ready = push_ready;
    assign accept      = in_ch.valid && push_ready;

    // Classify the incoming word and work out the next held-byte state.
    always_comb
    begin
        bundle          = '0;
        pend_byte_next  = pend_byte_reg;
        pend_valid_next = pend_valid_reg;
        term_next       = term_reg;

        if (!term_reg)
        begin
            if (in_ch.data_byte == '0)
            begin
                bundle.c0_valid = pend_valid_reg;
                bundle.c0_first = pend_byte_reg;
                pend_valid_next = 1'b0;
                term_next       = 1'b1;
            end
            else if (pend_valid_reg)
            begin
                bundle.c0_valid = 1'b1;
                bundle.c0_first = pend_byte_reg;
                if (pair_forms(encoding_mode, pend_byte_reg, in_ch.data_byte))
                begin
                    bundle.c0_second = in_ch.data_byte;
                    bundle.c0_two    = 1'b1;
                    pend_valid_next  = 1'b0;
                end
                else
                begin
                    pend_byte_next = in_ch.data_byte;
                end
            end
            else
            begin
                pend_byte_next  = in_ch.data_byte;
                pend_valid_next = 1'b1;
            end
        end

        // The last word flushes any held byte and starts a fresh string.
        if (in_ch.last)
        begin
            bundle.c1_valid = pend_valid_next;
            bundle.c1_byte  = pend_byte_next;
            bundle.end_mark = 1'b1;
            pend_byte_next  = '0;
            pend_valid_next = 1'b0;
            term_next       = 1'b0;
        end
    end

    assign push_data  = bundle;
    assign push_valid = accept && (bundle.c0_valid || bundle.c1_valid || bundle.end_mark);

    // Held-byte and termination state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_byte_reg  <= '0;
            pend_valid_reg <= 1'b0;
            term_reg       <= 1'b0;
        end
        else if (accept)
        begin
            pend_byte_reg  <= pend_byte_next;
            pend_valid_reg <= pend_valid_next;
            term_reg       <= term_next;
        end
    end

endmodule

FILE: rtl/mdt_queue.sv
// Two-entry queue of classified work between the front and back ends.
// Depends on mdt_pkg.
module mdt_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  mdt_pkg::bundle_t push_data,
    input  logic             push_valid,
    output logic             push_ready,
    output mdt_pkg::bundle_t head_data,
    output logic             head_valid,
    input  logic             pop
);
    import mdt_pkg::*;

    localparam int DEPTH = 2;
    localparam int CNT_W = $clog2(DEPTH+1);

    bundle_t                      entry_reg [DEPTH];
    logic [$clog2(DEPTH)-1:0]     wr_ptr_reg;
    logic [$clog2(DEPTH)-1:0]     rd_ptr_reg;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic                         do_push;
    logic                         do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    // Occupancy follows pushes and pops.
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!do_push && do_pop)
            count_next = count_reg - 1'b1;
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

FILE: rtl/mdt_back.sv
// Back end: walks the characters of each queued bundle, checks them against
// the delimiter set, tracks token state and drives the output register.
// Depends on mdt_pkg, mdt_if.
module mdt_back #(
    parameter int NUM_STORED = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mdt_pkg::bundle_t               head_data,
    input  logic                           head_valid,
    output logic                           pop,
    input  logic [mdt_pkg::COUNT_W-1:0]    delimiter_count,
    input  logic [mdt_pkg::DELIM_W-1:0]    delims [NUM_STORED],
    mdt_out_if.source                      out_ch
);
    import mdt_pkg::*;

    logic [1:0]        done_reg, done_next;
    logic              inside_reg, inside_next;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] first_reg, first_next;
    logic [BYTE_W-1:0] second_reg, second_next;
    logic              two_reg, two_next;
    logic              tok_reg, tok_next;
    logic              start_reg, start_next;
    logic              endm_reg, endm_next;
    logic              load;
    logic              sel0;
    logic              sel1;
    logic              final_elem;
    logic              is_delim;

    assign load = head_valid && (!out_valid_reg || out_ch.ready);
    assign sel0 = head_data.c0_valid && !done_reg[0];
    assign sel1 = !sel0 && head_data.c1_valid && !done_reg[1];

    // Pick the next element of the bundle and build its result.
    always_comb
    begin
        first_next  = '0;
        second_next = '0;
        two_next    = 1'b0;
        endm_next   = 1'b0;
        final_elem  = 1'b1;
        if (sel0)
        begin
            first_next  = head_data.c0_first;
            second_next = head_data.c0_two ? head_data.c0_second : '0;
            two_next    = head_data.c0_two;
            final_elem  = !head_data.c1_valid && !head_data.end_mark;
        end
        else if (sel1)
        begin
            first_next = head_data.c1_byte;
            final_elem = !head_data.end_mark;
        end
        else
        begin
            endm_next = 1'b1;
        end
    end

    // Compare the character with every enabled delimiter entry in parallel.
    always_comb
    begin
        is_delim = 1'b0;
        for (int i = 0; i < NUM_STORED; i++)
        begin
            if ((COUNT_W'(i) < delimiter_count) &&
                (delims[i][DELIM_TWO_BIT] == two_next) &&
                (delims[i][BYTE_W-1:0] == first_next) &&
                (!two_next || (delims[i][2*BYTE_W-1:BYTE_W] == second_next)))
                is_delim = 1'b1;
        end
    end

    // Token flags; the end marker closes the string and clears token state.
    always_comb
    begin
        if (endm_next)
        begin
            tok_next    = 1'b0;
            start_next  = 1'b0;
            inside_next = 1'b0;
        end
        else
        begin
            tok_next    = !is_delim;
            start_next  = !is_delim && !inside_reg;
            inside_next = !is_delim;
        end
        if (final_elem)
            done_next = '0;
        else
            done_next = done_reg | {sel1, sel0};
    end

    assign pop = load && final_elem;

    // Control state: element progress, token state and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= '0;
            inside_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                done_reg      <= done_next;
                inside_reg    <= inside_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            first_reg  <= first_next;
            second_reg <= second_next;
            two_reg    <= two_next;
            tok_reg    <= tok_next;
            start_reg  <= start_next;
            endm_reg   <= endm_next;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.first_byte  = first_reg;
    assign out_ch.second_byte = second_reg;
    assign out_ch.two_byte    = two_reg;
    assign out_ch.in_token    = tok_reg;
    assign out_ch.token_start = start_reg;
    assign out_ch.end_marker  = endm_reg;

endmodule

FILE: rtl/multibyte_delimiter_tokenizer.sv
// Top level of the multibyte delimiter tokenizer: configuration registers,
// front end, work queue and back end. Depends on mdt_pkg, mdt_if and the mdt_* modules.
//
//  Channel  Direction  Handshake          Word contents
//  in_ch    sink       valid/ready        data_byte, last
//  out_ch   source     valid/ready        first_byte, second_byte, two_byte,
//                                         in_token, token_start, end_marker
//  cfg      write      cfg_write          cfg_index, cfg_data
//
// One input byte is accepted per cycle while the two-entry queue has room.
// Each word yields zero to three results, sent one per cycle from the back end's
// output register while out_ch.ready is high, so throughput is one result per cycle.
// A completed character is written to a queue entry, then registered in the output register.
// rst_n resets control and configuration state at once; no clearing pass is needed.
// Output stalls fill the queue and then drop in_ch.ready; the sides stall independently.
module multibyte_delimiter_tokenizer #(
    parameter int NUM_DELIMS = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    mdt_in_if.sink                          in_ch,
    mdt_out_if.source                       out_ch,
    input  logic                            cfg_write,
    input  logic [mdt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mdt_pkg::DELIM_W-1:0]     cfg_data
);
    import mdt_pkg::*;

    // At most four delimiter registers are kept, as many as the configuration indexes address.
    localparam int NUM_STORED = (NUM_DELIMS < 4) ? NUM_DELIMS : 4;

    logic               encoding_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [DELIM_W-1:0] delim_reg [NUM_STORED];
    bundle_t            push_data;
    logic               push_valid;
    logic               push_ready;
    bundle_t            head_data;
    logic               head_valid;
    logic               pop;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            encoding_reg <= 1'b1;
            count_reg    <= '0;
            for (int i = 0; i < NUM_STORED; i++)
                delim_reg[i] <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_ENCODING:    encoding_reg <= cfg_data[0];
                CFG_DELIM_COUNT: count_reg    <= cfg_data[COUNT_W-1:0];
                default:
                begin
                    for (int i = 0; i < NUM_STORED; i++)
                    begin
                        if (cfg_index == CFG_DELIM_0 + CFG_IDX_W'(i))
                            delim_reg[i] <= cfg_data;
                    end
                end
            endcase
        end
    end

    mdt_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_ch         (in_ch),
        .encoding_mode (encoding_reg),
        .push_data     (push_data),
        .push_valid    (push_valid),
        .push_ready    (push_ready)
    );

    mdt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_data  (push_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .head_data  (head_data),
        .head_valid (head_valid),
        .pop        (pop)
    );

    mdt_back #(
        .NUM_STORED (NUM_STORED)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head_data       (head_data),
        .head_valid      (head_valid),
        .pop             (pop),
        .delimiter_count (count_reg),
        .delims          (delim_reg),
        .out_ch          (out_ch)
    );

endmodule
